FILE: rtl/oaht_pkg.sv
// shared types and constants for the open addressing hash table
package oaht_pkg;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW = 10;
  localparam int unsigned CntW = 11;
  localparam int unsigned KeyW = 31;
  localparam int unsigned CfgW = 11;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_STRATEGY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TABLE_SIZE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PROBES = 2'd2;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  localparam logic [1:0] STRAT_LINEAR = 2'd0;
  localparam logic [1:0] STRAT_QUAD = 2'd1;
  localparam logic [1:0] STRAT_DOUBLE = 2'd2;
  localparam logic [1:0] STRAT_SPARE = 2'd3;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;

  localparam logic [2:0] STAT_DONE = 3'd0;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [2:0] STAT_DUPLICATE = 3'd2;
  localparam logic [2:0] STAT_FULL = 3'd3;
  localparam logic [2:0] STAT_NO_FREE = 3'd4;
  localparam logic [2:0] STAT_REFUSED = 3'd5;

  typedef struct packed {
    logic [1:0] mode;
    logic [KeyW-1:0] key;
  } req_t;

  typedef struct packed {
    logic success;
    logic [2:0] status;
    logic [CntW-1:0] probe_count;
    logic [IdxW-1:0] slot_index;
    logic [CntW-1:0] item_count;
  } rsp_t;

  // classified work passed from front to back
  typedef struct packed {
    logic [1:0] mode;
    logic refused;
    logic [KeyW-1:0] key;
    logic [IdxW-1:0] home;
    logic [IdxW-1:0] step;
    logic single;
  } job_t;

  function automatic logic [CntW-1:0] clamp(input logic [CfgW-1:0] v);
    logic [CntW-1:0] r;
    r = v;
    if (v == '0) r = CntW'(1);
    else if (v > CfgW'(TableDepth)) r = CntW'(TableDepth);
    return r;
  endfunction
endpackage

FILE: rtl/oaht_if.sv
// valid/ready channel carrying one payload
interface oaht_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/oaht_front.sv
// front end: computes home slot and double-hash step for each request
module oaht_front (
  input  logic clk,
  input  logic rst,
  input  logic [oaht_pkg::CntW-1:0] ts,
  input  logic [1:0] mode,
  input  logic [oaht_pkg::KeyW-1:0] key,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output oaht_pkg::job_t job
);
  localparam int ProdW = oaht_pkg::KeyW + 32;
  typedef enum logic [2:0] {F_IDLE, F_HOME, F_DIV, F_REV, F_DONE} fstate_t;
  fstate_t st;
  logic [oaht_pkg::KeyW-1:0] rem;
  logic [oaht_pkg::KeyW-1:0] quo;
  logic [oaht_pkg::KeyW-1:0] quo_q;
  logic [ProdW-1:0] prod;
  logic [3:0] dig;
  logic [oaht_pkg::CntW+3:0] acc_mul;
  logic [oaht_pkg::CntW+3:0] acc_red;
  logic [oaht_pkg::CntW-1:0] acc;
  logic [oaht_pkg::KeyW+oaht_pkg::CntW-1:0] rr;
  logic [oaht_pkg::KeyW-1:0] rrem;
  logic [4:0] bitn;

  assign in_ready = (st == F_IDLE);
  assign out_valid = (st == F_DONE);
  // divide by ten through the reciprocal, exact for the 31-bit keys
  assign prod = ProdW'(rem) * ProdW'(32'hCCCCCCCD);
  assign quo = oaht_pkg::KeyW'(prod[ProdW-1:35]);
  assign dig = 4'(rem - ((quo_q << 3) + (quo_q << 1)));
  assign acc_mul = {4'd0, acc} * 15'd10 + 15'(dig);
  // acc < ts so acc*10+dig < 10*ts+10; reduce with a short subtract chain
  always_comb begin
    acc_red = acc_mul;
    for (int k = 3; k >= 0; k--) begin
      if (acc_red >= (15'(ts) << k)) acc_red = acc_red - (15'(ts) << k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
    end else begin
      unique case (st)
        F_IDLE: begin
          if (in_valid) begin
            job.mode <= mode;
            job.key <= key;
            job.refused <= (mode == oaht_pkg::MODE_INVALID);
            rem <= key;
            rr <= '0;
            rrem <= key;
            bitn <= 5'(oaht_pkg::KeyW - 1);
            acc <= '0;
            st <= F_HOME;
          end
        end
        F_HOME: begin
          // restoring remainder, one key bit per cycle
          logic [oaht_pkg::CntW:0] t;
          t = {rr[oaht_pkg::CntW-1:0], rrem[bitn]};
          if (t >= {1'b0, ts}) t = t - {1'b0, ts};
          rr <= {{oaht_pkg::KeyW{1'b0}}, t[oaht_pkg::CntW-1:0]};
          if (bitn == 0) begin
            job.home <= oaht_pkg::IdxW'(t);
            st <= F_DIV;
          end else begin
            bitn <= bitn - 5'd1;
          end
        end
        F_DIV: begin
          if (rem == '0) begin
            job.step <= oaht_pkg::IdxW'(acc);
            job.single <= (acc == '0);
            st <= F_DONE;
          end else begin
            quo_q <= quo;
            st <= F_REV;
          end
        end
        F_REV: begin
          acc <= oaht_pkg::CntW'(acc_red);
          rem <= quo_q;
          st <= F_DIV;
        end
        F_DONE: if (out_ready) st <= F_IDLE;
        default: st <= F_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/oaht_queue.sv
// two-entry queue between front and back
module oaht_queue (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  oaht_pkg::job_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output oaht_pkg::job_t out_data
);
  oaht_pkg::job_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop;
  assign in_ready = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> cnt != 2'd0) else $error("pop empty");
  a_count: assert property (@(posedge clk) disable iff (rst)
    push && !pop && cnt == 2'd0 |=> cnt == 2'd1) else $error("count");
`endif
endmodule

FILE: rtl/oaht_back.sv
// back end: probes the slot memory and updates the table
module oaht_back (
  input  logic clk,
  input  logic rst,
  input  logic [1:0] strategy,
  input  logic [oaht_pkg::CntW-1:0] ts,
  input  logic [oaht_pkg::CntW-1:0] lim,
  input  logic job_valid,
  output logic job_ready,
  input  oaht_pkg::job_t job,
  output logic rsp_valid,
  input  logic rsp_ready,
  output oaht_pkg::rsp_t rsp
);
  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_ADDR, B_READ, B_CHECK, B_OUT} bstate_t;
  bstate_t st;
  logic [oaht_pkg::KeyW-1:0] keys [oaht_pkg::TableDepth];
  logic [1:0] stat [oaht_pkg::TableDepth];
  logic [oaht_pkg::KeyW-1:0] rd_key;
  logic [1:0] rd_stat;
  logic [oaht_pkg::IdxW-1:0] raddr;
  logic [oaht_pkg::IdxW-1:0] clr;
  oaht_pkg::job_t cur;
  logic free_pass;
  logic [oaht_pkg::CntW-1:0] i;
  logic [oaht_pkg::CntW-1:0] count;
  logic [oaht_pkg::CntW-1:0] pos;
  logic [oaht_pkg::CntW-1:0] inc;
  logic [oaht_pkg::CntW:0] sum;
  logic [oaht_pkg::CntW-1:0] nxt;
  logic [oaht_pkg::CntW-1:0] qinc;
  logic [oaht_pkg::CntW-1:0] qinc_next;
  logic [oaht_pkg::CntW-1:0] qinc_first;
  logic [oaht_pkg::CntW:0] qadd;
  logic we_k, we_s;
  logic [oaht_pkg::IdxW-1:0] waddr;
  logic [1:0] wstat;

  assign job_ready = (st == B_IDLE);
  assign rsp_valid = (st == B_OUT);

  // quadratic step 2i+1 kept reduced mod ts
  assign qinc_first = (ts == oaht_pkg::CntW'(1)) ? '0 : oaht_pkg::CntW'(1);
  always_comb begin
    qadd = {1'b0, qinc} + (oaht_pkg::CntW+1)'(2);
    if (qadd >= {1'b0, ts}) qadd = qadd - {1'b0, ts};
    if (qadd >= {1'b0, ts}) qadd = qadd - {1'b0, ts};
    qinc_next = oaht_pkg::CntW'(qadd);
  end

  // next probe position, all terms below ts
  always_comb begin
    unique case (strategy)
      oaht_pkg::STRAT_QUAD: inc = qinc;
      oaht_pkg::STRAT_DOUBLE: inc = {1'b0, cur.step};
      default: inc = oaht_pkg::CntW'(1);
    endcase
    if (inc >= ts) inc = inc - ts;
    if (inc >= ts) inc = inc - ts;
    sum = {1'b0, pos} + {1'b0, inc};
    if (sum >= {1'b0, ts}) sum = sum - {1'b0, ts};
    nxt = oaht_pkg::CntW'(sum);
  end

  always_ff @(posedge clk) begin
    if (we_k) keys[waddr] <= cur.key;
    if (we_s) stat[waddr] <= wstat;
    rd_key <= keys[raddr];
    rd_stat <= stat[raddr];
  end

  always_comb begin
    we_k = 1'b0;
    we_s = 1'b0;
    waddr = pos[oaht_pkg::IdxW-1:0];
    wstat = oaht_pkg::SLOT_EMPTY;
    raddr = pos[oaht_pkg::IdxW-1:0];
    if (st == B_CLEAR) begin
      we_s = 1'b1;
      waddr = clr;
    end else if (st == B_CHECK) begin
      if (free_pass && rd_stat != oaht_pkg::SLOT_OCCUPIED) begin
        we_k = 1'b1;
        we_s = 1'b1;
        wstat = oaht_pkg::SLOT_OCCUPIED;
      end else if (!free_pass && cur.mode == oaht_pkg::MODE_REMOVE &&
                   rd_stat == oaht_pkg::SLOT_OCCUPIED && rd_key == cur.key) begin
        we_s = 1'b1;
        wstat = oaht_pkg::SLOT_DELETED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= B_CLEAR;
      clr <= '0;
      count <= '0;
    end else begin
      unique case (st)
        B_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == oaht_pkg::IdxW'(oaht_pkg::TableDepth - 1)) st <= B_IDLE;
        end
        B_IDLE: begin
          if (job_valid) begin
            cur <= job;
            pos <= {1'b0, job.home};
            i <= '0;
            qinc <= qinc_first;
            free_pass <= 1'b0;
            rsp.success <= 1'b0;
            rsp.probe_count <= '0;
            rsp.slot_index <= '0;
            rsp.item_count <= count;
            if (job.refused) begin
              rsp.status <= oaht_pkg::STAT_REFUSED;
              st <= B_OUT;
            end else if (job.mode == oaht_pkg::MODE_INSERT && count >= ts) begin
              rsp.status <= oaht_pkg::STAT_FULL;
              st <= B_OUT;
            end else begin
              st <= B_READ;
            end
          end
        end
        B_ADDR: st <= B_READ;
        B_READ: st <= B_CHECK;
        B_CHECK: begin
          logic last;
          last = (i + 1'b1 >= lim) ||
                 (strategy == oaht_pkg::STRAT_DOUBLE && cur.single);
          rsp.probe_count <= i + 1'b1;
          if (free_pass) begin
            if (rd_stat != oaht_pkg::SLOT_OCCUPIED) begin
              rsp.success <= 1'b1;
              rsp.status <= oaht_pkg::STAT_DONE;
              rsp.slot_index <= pos[oaht_pkg::IdxW-1:0];
              rsp.item_count <= count + 1'b1;
              count <= count + 1'b1;
              st <= B_OUT;
            end else if (last) begin
              rsp.status <= oaht_pkg::STAT_NO_FREE;
              st <= B_OUT;
            end else begin
              i <= i + 1'b1;
              qinc <= qinc_next;
              pos <= nxt;
              st <= B_ADDR;
            end
          end else if (rd_stat == oaht_pkg::SLOT_OCCUPIED && rd_key == cur.key) begin
            rsp.slot_index <= pos[oaht_pkg::IdxW-1:0];
            if (cur.mode == oaht_pkg::MODE_INSERT) begin
              rsp.status <= oaht_pkg::STAT_DUPLICATE;
            end else begin
              rsp.success <= 1'b1;
              rsp.status <= oaht_pkg::STAT_DONE;
              if (cur.mode == oaht_pkg::MODE_REMOVE && count != '0) begin
                count <= count - 1'b1;
                rsp.item_count <= count - 1'b1;
              end
            end
            st <= B_OUT;
          end else if (rd_stat == oaht_pkg::SLOT_EMPTY || last) begin
            if (cur.mode == oaht_pkg::MODE_INSERT) begin
              free_pass <= 1'b1;
              i <= '0;
              qinc <= qinc_first;
              pos <= {1'b0, cur.home};
              st <= B_ADDR;
            end else begin
              rsp.status <= oaht_pkg::STAT_NOT_FOUND;
              st <= B_OUT;
            end
          end else begin
            i <= i + 1'b1;
            qinc <= qinc_next;
            pos <= nxt;
            st <= B_ADDR;
          end
        end
        B_OUT: if (rsp_ready) st <= B_IDLE;
        default: st <= B_IDLE;
      endcase
    end
  end
`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= oaht_pkg::CntW'(oaht_pkg::TableDepth)) else $error("count overflow");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    st == B_CHECK |-> pos < ts) else $error("probe out of table");
  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    st == B_OUT && rsp.success |-> rsp.status == oaht_pkg::STAT_DONE)
    else $error("success with error status");
`endif
endmodule

FILE: rtl/open_addressing_hash_table.sv
// top level of the open addressing hash table
// front: accept, 31 remainder steps, divide and reverse per key digit (up to 10), handoff
// back: a job's first probe goes through read and check, each later one also through address;
// up to two probe passes for an insert, plus the taking of the job and the result transfer
// throughput: one item at a time in each half, overlapped through a two-entry queue
// reset: synchronous, then a clearing pass over all 1024 slots before the back takes its first item
module open_addressing_hash_table (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [oaht_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [oaht_pkg::CfgW-1:0] cfg_data,
  oaht_if.sink req,
  oaht_if.source rsp
);
  logic [1:0] strategy;
  logic [oaht_pkg::CfgW-1:0] table_size;
  logic [oaht_pkg::CfgW-1:0] max_probes;
  logic [oaht_pkg::CntW-1:0] ts, lim;
  logic fv, fr, qv, qr;
  oaht_pkg::job_t fj, qj;

  assign ts = oaht_pkg::clamp(table_size);
  assign lim = oaht_pkg::clamp(max_probes);

  always_ff @(posedge clk) begin
    if (rst) begin
      strategy <= oaht_pkg::STRAT_LINEAR;
      table_size <= oaht_pkg::CfgW'(1024);
      max_probes <= oaht_pkg::CfgW'(14);
    end else if (cfg_we) begin
      unique case (cfg_index)
        oaht_pkg::CFG_STRATEGY: strategy <= cfg_data[1:0];
        oaht_pkg::CFG_TABLE_SIZE: table_size <= cfg_data;
        oaht_pkg::CFG_MAX_PROBES: max_probes <= cfg_data;
        default: ;
      endcase
    end
  end

  oaht_front u_front (
    .clk(clk), .rst(rst), .ts(ts), .mode(req.data.mode), .key(req.data.key),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(fv), .out_ready(fr), .job(fj)
  );

  oaht_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(fv), .in_ready(fr), .in_data(fj),
    .out_valid(qv), .out_ready(qr), .out_data(qj)
  );

  oaht_back u_back (
    .clk(clk), .rst(rst), .strategy(strategy), .ts(ts), .lim(lim),
    .job_valid(qv), .job_ready(qr), .job(qj),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(rsp.data)
  );
endmodule

FILE: dv/open_addressing_hash_table_tb.sv
// testbench for the open addressing hash table: directed and random operations checked
// against a behavioral model of the slot table
module open_addressing_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [oaht_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [oaht_pkg::CfgW-1:0] cfg_data = '0;

  oaht_if #(.T(oaht_pkg::req_t)) req_ch (clk);
  oaht_if #(.T(oaht_pkg::rsp_t)) rsp_ch (clk);

  open_addressing_hash_table dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model of the table
  logic [1:0] model_status [oaht_pkg::TableDepth];
  logic [oaht_pkg::KeyW-1:0] model_keys [oaht_pkg::TableDepth];
  int model_count;
  logic [1:0] strat_cfg;
  logic [oaht_pkg::CfgW-1:0] size_cfg;
  logic [oaht_pkg::CfgW-1:0] probes_cfg;

  oaht_pkg::rsp_t expected_rsps [$];
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  logic [oaht_pkg::KeyW-1:0] key_pool [$];

  function automatic int eff_range(logic [oaht_pkg::CfgW-1:0] v);
    if (v == 0) return 1;
    if (v > oaht_pkg::TableDepth) return oaht_pkg::TableDepth;
    return int'(v);
  endfunction

  function automatic int probe_at(logic [oaht_pkg::KeyW-1:0] k, int i);
    longint unsigned ts, home, step, kk;
    ts = eff_range(size_cfg);
    home = k % ts;
    if (strat_cfg == oaht_pkg::STRAT_QUAD) return int'((home + i * i) % ts);
    if (strat_cfg == oaht_pkg::STRAT_DOUBLE) begin
      step = 0;
      kk = k;
      while (kk != 0) begin
        step = (step * 10 + kk % 10) % ts;
        kk = kk / 10;
      end
      if (step == 0) return (i == 0) ? int'(home) : -1;
      return int'((home + i * step) % ts);
    end
    return int'((home + i) % ts);
  endfunction

  function automatic int lookup_key(logic [oaht_pkg::KeyW-1:0] k, output int used);
    int s;
    used = 0;
    for (int i = 0; i < eff_range(probes_cfg); i++) begin
      s = probe_at(k, i);
      if (s < 0) break;
      used = i + 1;
      if (model_status[s] == oaht_pkg::SLOT_EMPTY) return -1;
      if (model_status[s] == oaht_pkg::SLOT_OCCUPIED && model_keys[s] == k) return s;
    end
    return -1;
  endfunction

  function automatic int lookup_free(logic [oaht_pkg::KeyW-1:0] k, output int used);
    int s;
    used = 0;
    for (int i = 0; i < eff_range(probes_cfg); i++) begin
      s = probe_at(k, i);
      if (s < 0) break;
      used = i + 1;
      if (model_status[s] != oaht_pkg::SLOT_OCCUPIED) return s;
    end
    return -1;
  endfunction

  function automatic oaht_pkg::rsp_t apply_op(logic [1:0] m, logic [oaht_pkg::KeyW-1:0] k);
    oaht_pkg::rsp_t r;
    int s;
    int used;
    r = '0;
    r.status = oaht_pkg::STAT_REFUSED;
    if (m == oaht_pkg::MODE_SEARCH || m == oaht_pkg::MODE_REMOVE) begin
      s = lookup_key(k, used);
      r.probe_count = oaht_pkg::CntW'(used);
      if (s >= 0) begin
        r.success = 1'b1;
        r.status = oaht_pkg::STAT_DONE;
        r.slot_index = oaht_pkg::IdxW'(s);
        if (m == oaht_pkg::MODE_REMOVE) begin
          model_status[s] = oaht_pkg::SLOT_DELETED;
          if (model_count > 0) model_count--;
        end
      end else begin
        r.status = oaht_pkg::STAT_NOT_FOUND;
      end
    end else if (m == oaht_pkg::MODE_INSERT) begin
      if (model_count >= eff_range(size_cfg)) begin
        r.status = oaht_pkg::STAT_FULL;
      end else begin
        s = lookup_key(k, used);
        if (s >= 0) begin
          r.status = oaht_pkg::STAT_DUPLICATE;
          r.probe_count = oaht_pkg::CntW'(used);
          r.slot_index = oaht_pkg::IdxW'(s);
        end else begin
          s = lookup_free(k, used);
          r.probe_count = oaht_pkg::CntW'(used);
          if (s >= 0) begin
            model_keys[s] = k;
            model_status[s] = oaht_pkg::SLOT_OCCUPIED;
            model_count++;
            r.success = 1'b1;
            r.status = oaht_pkg::STAT_DONE;
            r.slot_index = oaht_pkg::IdxW'(s);
          end else begin
            r.status = oaht_pkg::STAT_NO_FREE;
          end
        end
      end
    end
    r.item_count = oaht_pkg::CntW'(model_count);
    return r;
  endfunction

  task automatic send_op(logic [1:0] m, logic [oaht_pkg::KeyW-1:0] k);
    oaht_pkg::req_t item;
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    item.mode = m;
    item.key = k;
    req_ch.valid <= 1'b1;
    req_ch.data <= item;
    expected_rsps.push_back(apply_op(m, k));
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic configure(logic [1:0] st, logic [oaht_pkg::CfgW-1:0] ts,
                           logic [oaht_pkg::CfgW-1:0] mp);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= oaht_pkg::CFG_STRATEGY;
    cfg_data <= oaht_pkg::CfgW'(st);
    @(posedge clk);
    cfg_index <= oaht_pkg::CFG_TABLE_SIZE;
    cfg_data <= ts;
    @(posedge clk);
    cfg_index <= oaht_pkg::CFG_MAX_PROBES;
    cfg_data <= mp;
    @(posedge clk);
    cfg_we <= 1'b0;
    strat_cfg = st;
    size_cfg = ts;
    probes_cfg = mp;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    oaht_pkg::rsp_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %p", rsp_ch.data);
      end else begin
        exp_r = expected_rsps.pop_front();
        if (rsp_ch.data.success !== exp_r.success || rsp_ch.data.status !== exp_r.status ||
            rsp_ch.data.probe_count !== exp_r.probe_count ||
            rsp_ch.data.slot_index !== exp_r.slot_index ||
            rsp_ch.data.item_count !== exp_r.item_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %p got %p", exp_r, rsp_ch.data);
        end
      end
    end
  end

  task automatic test_directed();
    configure(oaht_pkg::STRAT_LINEAR, 11'd4, 11'd14);
    send_op(oaht_pkg::MODE_INSERT, 31'd0);
    send_op(oaht_pkg::MODE_INSERT, 31'd4);
    send_op(oaht_pkg::MODE_INSERT, 31'd8);
    send_op(oaht_pkg::MODE_SEARCH, 31'd4);
    send_op(oaht_pkg::MODE_REMOVE, 31'd4);
    send_op(oaht_pkg::MODE_SEARCH, 31'd8);
    send_op(oaht_pkg::MODE_SEARCH, 31'd4);
    send_op(oaht_pkg::MODE_INSERT, 31'd12);
    send_op(oaht_pkg::MODE_INSERT, 31'd8);
    send_op(oaht_pkg::MODE_INSERT, 31'h7fffffff);
    send_op(oaht_pkg::MODE_INSERT, 31'd100);
    send_op(oaht_pkg::MODE_SEARCH, 31'd9);
    send_op(oaht_pkg::MODE_INVALID, 31'd5);
    send_op(oaht_pkg::MODE_INVALID, 31'h7fffffff);
    send_op(oaht_pkg::MODE_SEARCH, 31'h7fffffff);
    send_op(oaht_pkg::MODE_REMOVE, 31'd0);
    send_op(oaht_pkg::MODE_REMOVE, 31'd0);
    send_op(oaht_pkg::MODE_SEARCH, 31'd0);
    configure(oaht_pkg::STRAT_QUAD, 11'd4, 11'd2);
    send_op(oaht_pkg::MODE_INSERT, 31'd16);
    send_op(oaht_pkg::MODE_SEARCH, 31'd12);
    configure(oaht_pkg::STRAT_DOUBLE, 11'd5, 11'd5);
    send_op(oaht_pkg::MODE_INSERT, 31'd5);
    send_op(oaht_pkg::MODE_INSERT, 31'd10);
  endtask

  task automatic test_random_phase(int idx, logic [1:0] st, logic [oaht_pkg::CfgW-1:0] ts,
                                   logic [oaht_pkg::CfgW-1:0] mp, int n);
    int span;
    int pick;
    logic [1:0] m;
    logic [oaht_pkg::KeyW-1:0] k;
    configure(st, ts, mp);
    case (idx % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
    span = 4 * eff_range(ts) + 8;
    key_pool.delete();
    for (int i = 0; i < 24; i++) key_pool.push_back(oaht_pkg::KeyW'($urandom_range(span)));
    key_pool.push_back(31'h7fffffff);
    key_pool.push_back(31'd0);
    for (int i = 0; i < n; i++) begin
      pick = int'($urandom_range(99));
      if (pick < 50) m = oaht_pkg::MODE_INSERT;
      else if (pick < 78) m = oaht_pkg::MODE_SEARCH;
      else if (pick < 95) m = oaht_pkg::MODE_REMOVE;
      else m = oaht_pkg::MODE_INVALID;
      if ($urandom_range(9) == 0) k = oaht_pkg::KeyW'($urandom());
      else k = key_pool[$urandom_range(key_pool.size() - 1)];
      send_op(m, k);
    end
  endtask

  task automatic test_random();
    test_random_phase(0, oaht_pkg::STRAT_LINEAR, 11'd16, 11'd14, 170);
    test_random_phase(1, oaht_pkg::STRAT_QUAD, 11'd16, 11'd14, 170);
    test_random_phase(2, oaht_pkg::STRAT_DOUBLE, 11'd16, 11'd14, 170);
    test_random_phase(3, oaht_pkg::STRAT_SPARE, 11'd7, 11'd3, 150);
    test_random_phase(4, oaht_pkg::STRAT_LINEAR, 11'd1, 11'd1, 80);
    test_random_phase(5, oaht_pkg::STRAT_QUAD, 11'd0, 11'd0, 80);
    test_random_phase(6, oaht_pkg::STRAT_DOUBLE, 11'd1024, 11'd1024, 150);
    test_random_phase(7, oaht_pkg::STRAT_DOUBLE, 11'd2047, 11'd2047, 100);
    test_random_phase(8, oaht_pkg::STRAT_QUAD, 11'd13, 11'd1024, 40);
    test_random_phase(9, oaht_pkg::STRAT_LINEAR, 11'd1024, 11'd14, 120);
    test_random_phase(10, oaht_pkg::STRAT_DOUBLE, 11'd23, 11'd8, 100);
  endtask

  initial begin
    for (int i = 0; i < oaht_pkg::TableDepth; i++) model_status[i] = oaht_pkg::SLOT_EMPTY;
    model_count = 0;
    strat_cfg = oaht_pkg::STRAT_LINEAR;
    size_cfg = 11'd1024;
    probes_cfg = 11'd14;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
